// ===== hdl/bmf_pkg.sv =====
// Shared constants for the Bloom membership filter: key width, memory word geometry, op codes.
`timescale 1ns / 1ps
`default_nettype none
package bmf_pkg;

    localparam int KEY_W     = 64;
    localparam int WORD_W    = 64;
    localparam int WORD_SH   = 6;
    localparam int OP_W      = 2;
    localparam int HASH_W    = 2;
    localparam int CNT_W     = 7;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Index of the last of the three hash positions.
    localparam logic [HASH_W-1:0] HASH_LAST = 2'd2;

endpackage
`default_nettype wire

// ===== hdl/bmf_mod_unit.sv =====
// Shared reduction unit: one 64-bit key half modulo the filter size.
`timescale 1ns / 1ps
`default_nettype none
module bmf_mod_unit #(
    parameter int MODULUS = 8192,
    parameter int POS_W   = 13
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     load,
    input  wire logic [bmf_pkg::KEY_W-1:0] value,
    output logic                          done,
    output logic [POS_W-1:0]              rem
);
    import bmf_pkg::*;

    localparam bit IS_POW2 = ((1 << POS_W) == MODULUS);

    generate
        if (IS_POW2) begin : g_mask
            // A power-of-two size only needs the low bits.
            logic             done_reg;
            logic [POS_W-1:0] rem_reg;

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    done_reg <= 1'b0;
                end
                else begin
                    done_reg <= load;
                end
            end

            always_ff @(posedge clk) begin
                if (load) begin
                    rem_reg <= value[POS_W-1:0];
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
        else begin : g_recip
            // Other sizes: the key is reduced twelve bits at a time, most significant
            // first. Each step forms rem * 4096 + digit, estimates the quotient with a
            // reciprocal multiply, subtracts that multiple and corrects once.
            localparam int DIG_W = 12;
            localparam int N_DIG = 6;
            localparam int SH_W  = DIG_W * N_DIG;
            localparam int MUL_W = 32;
            localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << MUL_W) / 64'(MODULUS));
            localparam logic [MUL_W-1:0] MOD_C = MUL_W'(MODULUS);

            localparam logic [1:0] PH_FORM = 2'd0;
            localparam logic [1:0] PH_EST  = 2'd1;
            localparam logic [1:0] PH_MUL  = 2'd2;
            localparam logic [1:0] PH_FIX  = 2'd3;

            logic               busy_reg;
            logic               done_reg;
            logic [1:0]         ph_reg;
            logic [2:0]         dig_reg;
            logic [SH_W-1:0]    sh_reg;
            logic [POS_W-1:0]   rem_reg;
            logic [MUL_W-1:0]   t_reg;
            logic [DIG_W-1:0]   q_reg;
            logic [MUL_W-1:0]   qm_reg;
            logic [2*MUL_W-1:0] prod;
            logic [MUL_W-1:0]   diff;
            logic [MUL_W-1:0]   diff_fix;

            always_comb begin
                prod     = {{MUL_W{1'b0}}, t_reg} * {{MUL_W{1'b0}}, RECIP};
                diff     = t_reg - qm_reg;
                diff_fix = diff - MOD_C;
            end

            always_ff @(posedge clk or negedge rst_n) begin
                if (!rst_n) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b0;
                    ph_reg   <= PH_FORM;
                    dig_reg  <= '0;
                end
                else begin
                    done_reg <= 1'b0;
                    if (load) begin
                        busy_reg <= 1'b1;
                        ph_reg   <= PH_FORM;
                        dig_reg  <= '0;
                    end
                    else if (busy_reg) begin
                        case (ph_reg)
                            PH_FORM: begin
                                ph_reg <= PH_EST;
                            end
                            PH_EST: begin
                                ph_reg <= PH_MUL;
                            end
                            PH_MUL: begin
                                ph_reg <= PH_FIX;
                            end
                            PH_FIX: begin
                                ph_reg  <= PH_FORM;
                                dig_reg <= dig_reg + 3'd1;
                                if (dig_reg == 3'(N_DIG - 1)) begin
                                    busy_reg <= 1'b0;
                                    done_reg <= 1'b1;
                                end
                            end
                            default: begin
                                ph_reg <= PH_FORM;
                            end
                        endcase
                    end
                end
            end

            always_ff @(posedge clk) begin
                if (load) begin
                    sh_reg  <= SH_W'(value);
                    rem_reg <= '0;
                end
                else if (busy_reg) begin
                    case (ph_reg)
                        PH_FORM: begin
                            t_reg  <= MUL_W'({rem_reg, sh_reg[SH_W-1 -: DIG_W]});
                            sh_reg <= {sh_reg[SH_W-DIG_W-1:0], {DIG_W{1'b0}}};
                        end
                        PH_EST: begin
                            q_reg <= prod[MUL_W +: DIG_W];
                        end
                        PH_MUL: begin
                            qm_reg <= {{(MUL_W-DIG_W){1'b0}}, q_reg} * MOD_C;
                        end
                        PH_FIX: begin
                            if (diff >= MOD_C) begin
                                rem_reg <= diff_fix[POS_W-1:0];
                            end
                            else begin
                                rem_reg <= diff[POS_W-1:0];
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            assign done = done_reg;
            assign rem  = rem_reg;
        end
    endgenerate

endmodule
`default_nettype wire

// ===== hdl/bloom_membership_filter_top.sv =====
// Top level of the Bloom membership filter: sequencer, bit memory and result strobe.
// Insert and query reduce each of the three hash positions in turn, then read one memory
// word and test its bit or, for an insert, set it; a size that is not a power of two uses
// the reciprocal path of the reduction unit. Short keys and op code three finish without
// touching the memory, and a clear zeroes one 64-bit memory word per cycle. The one-cycle
// done strobe follows the final step and cannot be stalled. After reset, busy stays high while every word is zeroed.
`timescale 1ns / 1ps
`default_nettype none
module bloom_membership_filter_top #(
    parameter int FILTER_BITS = 8192
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [bmf_pkg::OP_W-1:0]   op,
    input  wire logic [bmf_pkg::KEY_W-1:0]  key_low,
    input  wire logic [bmf_pkg::KEY_W-1:0]  key_high,
    input  wire logic                       key_short,
    output logic                            done,
    output logic                            may_exist
);
    import bmf_pkg::*;

    // Bit position width and memory geometry follow from the filter size.
    localparam int POS_W  = $clog2(FILTER_BITS);
    localparam int DEPTH  = (FILTER_BITS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MOD  = 2'd1;
    localparam logic [1:0] ST_CHK  = 2'd2;
    localparam logic [1:0] ST_CLR  = 2'd3;

    // Control registers.
    logic [1:0]        st_reg, st_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic              hit_reg, hit_next;
    logic              clr_op_reg, clr_op_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic              done_reg, done_next;
    logic              may_reg, may_next;

    // Payload registers of the beat being worked on.
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  a_reg;
    logic [KEY_W-1:0]  b_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_SH-1:0] bit_reg;
    logic [WORD_W-1:0] rd_data_reg;

    logic              accept;
    logic              mod_load;
    logic [KEY_W-1:0]  mod_value;
    logic              mod_done;
    logic [POS_W-1:0]  mod_rem;
    logic [POS_W-1:0]  word_pos;
    logic [ADDR_W-1:0] rem_addr;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] filter_mem [DEPTH];

    assign accept = start && (st_reg == ST_IDLE);
    assign busy   = (st_reg != ST_IDLE);

    // The reduced position splits into a memory word and a bit within that word.
    assign word_pos = mod_rem >> WORD_SH;
    assign rem_addr = word_pos[ADDR_W-1:0];

    // The first position comes straight from the port, the later ones from the
    // captured key: the high half, then the XOR of both halves.
    always_comb begin
        if (st_reg == ST_IDLE) begin
            mod_value = key_low;
        end
        else if (hash_reg == '0) begin
            mod_value = b_reg;
        end
        else begin
            mod_value = a_reg ^ b_reg;
        end
    end

    bmf_mod_unit #(
        .MODULUS (FILTER_BITS),
        .POS_W   (POS_W)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (mod_load),
        .value (mod_value),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    // Sequencer: one position at a time through the shared reduction unit, then
    // a read of the word and, in the following cycle, the test or the set.
    always_comb begin
        st_next       = st_reg;
        hash_next     = hash_reg;
        hit_next      = hit_reg;
        clr_op_next   = clr_op_reg;
        clr_addr_next = clr_addr_reg;
        done_next     = 1'b0;
        may_next      = may_reg;
        mod_load      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = addr_reg;
        mem_wdata     = rd_data_reg | (WORD_W'(1) << bit_reg);

        case (st_reg)
            ST_IDLE: begin
                if (accept) begin
                    hash_next = '0;
                    hit_next  = 1'b1;
                    case (op)
                        OP_INSERT, OP_QUERY: begin
                            if (key_short) begin
                                done_next = 1'b1;
                                may_next  = (op == OP_QUERY);
                            end
                            else begin
                                mod_load = 1'b1;
                                st_next  = ST_MOD;
                            end
                        end
                        OP_CLEAR: begin
                            clr_op_next   = 1'b1;
                            clr_addr_next = '0;
                            st_next       = ST_CLR;
                        end
                        default: begin
                            done_next = 1'b1;
                            may_next  = 1'b0;
                        end
                    endcase
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    st_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (op_reg == OP_INSERT) begin
                    mem_we = 1'b1;
                end
                hit_next = hit_reg & rd_data_reg[bit_reg];
                if (hash_reg == HASH_LAST) begin
                    done_next = 1'b1;
                    may_next  = (op_reg == OP_QUERY) && hit_next;
                    st_next   = ST_IDLE;
                end
                else begin
                    hash_next = hash_reg + HASH_W'(1);
                    mod_load  = 1'b1;
                    st_next   = ST_MOD;
                end
            end
            ST_CLR: begin
                // Zero one word per cycle; used after reset and for a clear beat.
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                mem_wdata     = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                    st_next     = ST_IDLE;
                    clr_op_next = 1'b0;
                    if (clr_op_reg) begin
                        done_next = 1'b1;
                        may_next  = 1'b0;
                    end
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            st_reg       <= ST_CLR;
            hash_reg     <= '0;
            hit_reg      <= 1'b0;
            clr_op_reg   <= 1'b0;
            clr_addr_reg <= '0;
            done_reg     <= 1'b0;
            may_reg      <= 1'b0;
        end
        else begin
            st_reg       <= st_next;
            hash_reg     <= hash_next;
            hit_reg      <= hit_next;
            clr_op_reg   <= clr_op_next;
            clr_addr_reg <= clr_addr_next;
            done_reg     <= done_next;
            may_reg      <= may_next;
        end
    end

    always_ff @(posedge clk) begin
        if (accept) begin
            op_reg <= op;
            a_reg  <= key_low;
            b_reg  <= key_high;
        end
        if ((st_reg == ST_MOD) && mod_done) begin
            addr_reg <= rem_addr;
            bit_reg  <= mod_rem[WORD_SH-1:0];
        end
    end

    // Bit array, one write port and one registered read port.
    always_ff @(posedge clk) begin
        if (mem_we) begin
            filter_mem[mem_waddr] <= mem_wdata;
        end
        if ((st_reg == ST_MOD) && mod_done) begin
            rd_data_reg <= filter_mem[rem_addr];
        end
    end

    assign done      = done_reg;
    assign may_exist = may_reg;

endmodule
`default_nettype wire
